// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define TBDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that a condition never holds.
`define TBDA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/tbda_pkg.sv =====
package tbda_pkg;

  localparam int unsigned LanesDef   = 8;
  localparam int unsigned SumBitsDef = 16;
  localparam int unsigned PlaneW     = 8;
  localparam int unsigned BColsW     = 64;
  localparam int unsigned VcW        = 4;
  localparam int unsigned ColW       = 3;
  localparam int unsigned DotW       = 16;

  // Per-cycle control broadcast to every lane cell.
  typedef struct packed {
    logic step;   // input transaction accepted
    logic last;   // accepted transaction closes the run
    logic shift;  // output transaction taken, drain chain moves
  } cell_ctrl_t;

endpackage

// ===== rtl/tbda_in_if.sv =====
interface tbda_in_if;
  logic                              valid;
  logic                              ready;
  logic [tbda_pkg::PlaneW-1:0]       a_pos;
  logic [tbda_pkg::PlaneW-1:0]       a_neg;
  logic [tbda_pkg::BColsW-1:0]       b_cols;
  logic                              last_step;
  logic [tbda_pkg::VcW-1:0]          valid_cols;

  modport source (output valid, a_pos, a_neg, b_cols, last_step, valid_cols, input ready);
  modport sink   (input valid, a_pos, a_neg, b_cols, last_step, valid_cols, output ready);
endinterface

// ===== rtl/tbda_out_if.sv =====
interface tbda_out_if;
  logic                              valid;
  logic                              ready;
  logic [tbda_pkg::ColW-1:0]         column;
  logic signed [tbda_pkg::DotW-1:0]  dot_sum;
  logic                              last_result;

  modport source (output valid, column, dot_sum, last_result, input ready);
  modport sink   (input valid, column, dot_sum, last_result, output ready);
endinterface

// ===== rtl/ternary_binary_dot_accumulator.sv =====
// Ternary-by-binary dot-product accumulator.
// in_i (sink): one k step per transaction: a_pos/a_neg weight bitplanes, one
//   activation byte per column lane in b_cols, last_step closing a run and
//   valid_cols giving how many lane sums the run emits (clamped to LANES).
// out_o (source): one transaction per emitted sum: column, saturated dot_sum,
//   last_result on the final sum of the run.
// Throughput: one input transaction per cycle while no last_step transaction
//   waits on a drain; each lane cell updates its accumulator in the accept
//   cycle. A run end copies all lane sums into the drain chain in that same
//   cycle and clears the accumulators.
// Output: the first sum is presented in the cycle after the last_step
//   transaction; following sums leave at one per cycle while ready stays
//   high, the drain chain shifting one lane toward lane 0 per out_o transaction.
// Non-last steps are accepted while a drain is in progress. A last_step
//   transaction waits until the drain chain is empty or its final sum is
//   being taken, so a run end stalls while the run before it drains, longer
//   when the receiver stalls.
// Receiver stall: out_o holds its sum; the drain chain and counters freeze.
// Reset: asynchronous, active low; accumulators clear, no output pending.
module ternary_binary_dot_accumulator #(
  parameter int unsigned LANES    = tbda_pkg::LanesDef,
  parameter int unsigned SUM_BITS = tbda_pkg::SumBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  tbda_in_if.sink    in_i,
  tbda_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(LANES + 1);

  tbda_pkg::cell_ctrl_t           ctrl;
  logic [SUM_BITS-1:0]            drain [LANES];
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [tbda_pkg::ColW-1:0]      col_q, col_d;
  logic [CntW-1:0]                vc_clamp;
  logic                           in_fire, out_fire, drain_busy, drain_done;

  // Drain state: sums left to emit and the column of the one on display.
  assign drain_busy = (cnt_q != '0);
  assign out_fire   = out_o.valid && out_o.ready;
  assign drain_done = out_fire && (cnt_q == CntW'(1));

  assign in_i.ready = !in_i.last_step || !drain_busy || drain_done;
  assign in_fire    = in_i.valid && in_i.ready;

  assign vc_clamp = (in_i.valid_cols > tbda_pkg::VcW'(LANES)) ? CntW'(LANES)
                                                              : CntW'(in_i.valid_cols);

  assign ctrl.step  = in_fire;
  assign ctrl.last  = in_i.last_step;
  assign ctrl.shift = out_fire;

  always_comb begin
    cnt_d = cnt_q;
    col_d = col_q;
    priority if (in_fire && in_i.last_step) begin
      cnt_d = vc_clamp;
      col_d = '0;
    end else if (out_fire) begin
      cnt_d = cnt_q - CntW'(1);
      col_d = col_q + tbda_pkg::ColW'(1);
    end else begin
      cnt_d = cnt_q;
      col_d = col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      col_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      col_q <= col_d;
    end
  end

  // Row of lane cells; drain data moves toward lane 0.
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    logic [SUM_BITS-1:0] shift_in;
    if (c == LANES - 1) begin : g_tail
      assign shift_in = '0;
    end else begin : g_mid
      assign shift_in = drain[c+1];
    end

    tbda_cell #(
      .SumBits (SUM_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .a_pos_i (in_i.a_pos),
      .a_neg_i (in_i.a_neg),
      .b_i     (in_i.b_cols[tbda_pkg::PlaneW*c +: tbda_pkg::PlaneW]),
      .shift_i (shift_in),
      .drain_o (drain[c])
    );
  end

  assign out_o.valid       = drain_busy;
  assign out_o.column      = col_q;
  assign out_o.last_result = (cnt_q == CntW'(1));

  if (SUM_BITS >= tbda_pkg::DotW) begin : g_dot_trunc
    assign out_o.dot_sum = drain[0][tbda_pkg::DotW-1:0];
  end else begin : g_dot_sext
    assign out_o.dot_sum = {{(tbda_pkg::DotW-SUM_BITS){drain[0][SUM_BITS-1]}}, drain[0]};
  end

`include "assert_macros.svh"

  `TBDA_ASSERT(a_drain_continues, out_fire && !out_o.last_result |=> out_o.valid, "drain stopped early")
  `TBDA_ASSERT(a_drain_ends, out_fire && out_o.last_result && !(in_fire && in_i.last_step) |=> !out_o.valid, "drain ran past last sum")
  `TBDA_ASSERT(a_run_starts_lane0, in_fire && in_i.last_step && (in_i.valid_cols != '0) |=> out_o.valid && (out_o.column == '0), "run end did not present lane 0")

endmodule

// ===== rtl/tbda_cell.sv =====
// One column lane: popcount difference, saturating accumulator, drain stage.
module tbda_cell #(
  parameter int unsigned SumBits = tbda_pkg::SumBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tbda_pkg::cell_ctrl_t             ctrl_i,
  input  logic [tbda_pkg::PlaneW-1:0]      a_pos_i,
  input  logic [tbda_pkg::PlaneW-1:0]      a_neg_i,
  input  logic [tbda_pkg::PlaneW-1:0]      b_i,
  input  logic [SumBits-1:0]               shift_i,
  output logic [SumBits-1:0]               drain_o
);

  localparam int unsigned PcW = $clog2(tbda_pkg::PlaneW + 1);

  logic [tbda_pkg::PlaneW-1:0] plus_vec, minus_vec;
  logic [PcW-1:0]              pc_plus, pc_minus;
  logic signed [PcW:0]         diff;
  logic signed [SumBits:0]     sum_ext;
  logic [SumBits-1:0]          sat;
  logic [SumBits-1:0]          acc_q, acc_d;
  logic [SumBits-1:0]          drain_q, drain_d;

  assign plus_vec  = (a_pos_i | b_i) & (a_neg_i | ~b_i);
  assign minus_vec = (a_pos_i | ~b_i) & (a_neg_i | b_i);

  always_comb begin
    pc_plus  = '0;
    pc_minus = '0;
    for (int i = 0; i < int'(tbda_pkg::PlaneW); i++) begin
      pc_plus  = pc_plus + PcW'(plus_vec[i]);
      pc_minus = pc_minus + PcW'(minus_vec[i]);
    end
  end

  assign diff    = $signed({1'b0, pc_plus}) - $signed({1'b0, pc_minus});
  assign sum_ext = $signed({acc_q[SumBits-1], acc_q}) + (SumBits+1)'(diff);

  // Clamp when the top two bits disagree.
  always_comb begin
    if (sum_ext[SumBits] != sum_ext[SumBits-1]) begin
      sat = sum_ext[SumBits] ? {1'b1, {(SumBits-1){1'b0}}} : {1'b0, {(SumBits-1){1'b1}}};
    end else begin
      sat = sum_ext[SumBits-1:0];
    end
  end

  always_comb begin
    acc_d   = acc_q;
    drain_d = drain_q;
    if (ctrl_i.step) begin
      acc_d = ctrl_i.last ? '0 : sat;
    end
    priority if (ctrl_i.step && ctrl_i.last) begin
      drain_d = sat;
    end else if (ctrl_i.shift) begin
      drain_d = shift_i;
    end else begin
      drain_d = drain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drain_q <= drain_d;
  end

  assign drain_o = drain_q;

endmodule
